/* sv/keyboard_controller_8042_core_defines.svh */
// assertion macros for the keyboard controller core
`ifndef KEYBOARD_CONTROLLER_8042_CORE_DEFINES_SVH
`define KEYBOARD_CONTROLLER_8042_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KBC_ASSERT_NOW(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define KBC_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* sv/kbc_pkg.sv */
// shared types, codes and constants of the keyboard controller
package kbc_pkg;

	// byte queue geometry
	localparam int FifoDepth = 16;
	localparam int PtrW      = $clog2(FifoDepth);

	// transfer kinds
	localparam logic [1:0] FN_READ  = 2'd0;
	localparam logic [1:0] FN_WRITE = 2'd1;
	localparam logic [1:0] FN_KBD   = 2'd2;

	// port selects
	localparam logic [1:0] PORT_DATA   = 2'd0;
	localparam logic [1:0] PORT_CMD    = 2'd1;
	localparam logic [1:0] PORT_GATE   = 2'd2;

	// controller commands
	localparam logic [7:0] CMD_READ_CB   = 8'h20;
	localparam logic [7:0] CMD_WRITE_CB  = 8'h60;
	localparam logic [7:0] CMD_SELF_TEST = 8'hAA;
	localparam logic [7:0] CMD_KBD_OFF   = 8'hAD;
	localparam logic [7:0] CMD_KBD_ON    = 8'hAE;
	localparam logic [7:0] CMD_AUX_OFF   = 8'hA7;
	localparam logic [7:0] CMD_AUX_ON    = 8'hA8;
	localparam logic [7:0] CMD_READ_IN   = 8'hC0;
	localparam logic [7:0] CMD_READ_OUT  = 8'hD0;
	localparam logic [7:0] CMD_WRITE_OUT = 8'hD1;
	localparam logic [7:0] CMD_WRITE_KBO = 8'hD3;
	localparam logic [7:0] CMD_WRITE_AUX = 8'hD4;
	localparam logic [7:0] CMD_READ_TST  = 8'hE0;
	localparam logic [7:0] CMD_PULSE_RST = 8'hFE;
	localparam logic [7:0] PEND_NONE     = 8'h00;

	// bytes returned to the host
	localparam logic [7:0] BYTE_ACK      = 8'hFA;
	localparam logic [7:0] BYTE_TEST_OK  = 8'h55;
	localparam logic [7:0] BYTE_BAT_OK   = 8'hAA;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] BYTE_NO_PORT  = 8'hFF;
	localparam logic [7:0] BYTE_RESET    = 8'hFF;

	// reset values
	localparam logic [7:0] STATUS_RST  = 8'h14;
	localparam logic [7:0] CB_RST      = 8'h45;
	localparam logic [7:0] OUTPORT_RST = 8'hDD;

	// control byte bits
	localparam int CB_IRQ_EN  = 0;
	localparam int CB_KBD_DIS = 4;
	localparam int CB_AUX_DIS = 5;

	// status bits
	localparam int ST_OBF = 0;
	localparam int ST_IBF = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT,
		ST_POP,
		ST_DONE
	} kbc_state_t;

	typedef struct packed {
		logic push;
		logic pop;
	} kbc_fifo_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} kbc_fifo_stat_t;

endpackage

/* sv/kbc_ram.sv */
// simple dual-port ram with registered read data
module kbc_ram #(
	parameter int Depth = 16,
	parameter int Width = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/kbc_fifo.sv */
// byte queue: head and tail pointers around the queue ram
module kbc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kbc_pkg::kbc_fifo_ctl_t ctl,
	input  logic [7:0]            push_data,
	output logic [7:0]            pop_data,
	output kbc_pkg::kbc_fifo_stat_t stat
);

	logic [kbc_pkg::PtrW-1:0] head_q;
	logic [kbc_pkg::PtrW-1:0] tail_q;
	logic [kbc_pkg::PtrW-1:0] head_nx;
	logic [kbc_pkg::PtrW-1:0] tail_nx;

	// wrap at the depth, which need not be a power of two
	assign head_nx = (head_q == kbc_pkg::PtrW'(kbc_pkg::FifoDepth - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == kbc_pkg::PtrW'(kbc_pkg::FifoDepth - 1)) ? '0 : tail_q + 1'b1;

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (head_nx == tail_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push) begin
				head_q <= head_nx;
			end
			if (ctl.pop) begin
				tail_q <= tail_nx;
			end
		end
	end

	kbc_ram #(
		.Depth (kbc_pkg::FifoDepth),
		.Width (8)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctl.push),
		.wr_addr (head_q),
		.wr_data (push_data),
		.rd_en   (ctl.pop),
		.rd_addr (tail_q),
		.rd_data (pop_data)
	);

endmodule

/* sv/keyboard_controller_8042_core.sv */
// top level of the 8042-style keyboard controller core
//
// usage: each input transfer is one bus read, one bus write or one keyboard
// byte (func), aimed at the data, command/status or A20 gate port
// (port_select), with write data or keyboard byte in value. every input
// transfer yields exactly one output transfer carrying read_data, the
// irq_request and cpu_reset_request pulses of that step and the gate_a20 level.
// both channels use valid/ready; an input transfer is taken only while the
// controller is idle, one item at a time.
// each item then runs exec, an emit step for each byte it pushes toward the host
// (0 to 3, each loaded into the output buffer, written to the queue ram or,
// with the queue full, dropped) or a pop step for a data-port read that refills
// the output buffer from the queue ram (registered read), then done.
// the result sits in an output register; if the receiver stalls, the next item
// is still taken and processed, and waits only to load the output register.
// reset: status 0x14, command byte 0x45, output port 0xDD, no pending command,
// queue empty, A20 low; the queue ram needs no clearing pass.
module keyboard_controller_8042_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [1:0] port_select,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       irq_request,
	output logic       cpu_reset_request,
	output logic       gate_a20
);

`include "keyboard_controller_8042_core_defines.svh"

	kbc_pkg::kbc_state_t state_q;
	kbc_pkg::kbc_state_t state_nx;

	// latched request
	logic [1:0] func_q;
	logic [1:0] port_q;
	logic [7:0] value_q;

	// architectural registers
	logic [7:0] status_q;
	logic [7:0] control_q;
	logic [7:0] out_port_q;
	logic [7:0] pending_q;
	logic [7:0] obuf_q;
	logic [7:0] gate_q;
	logic       a20_q;

	// per-step result under construction
	logic [7:0] rd_q;
	logic       irq_q;
	logic       rst_q;

	// bytes queued toward the host by this step
	logic [7:0] emit_q [3];
	logic [1:0] emit_n_q;
	logic [7:0] emit_d [3];
	logic [1:0] emit_n_d;

	// output register
	logic       out_valid_q;
	logic [7:0] out_rd_q;
	logic       out_irq_q;
	logic       out_rst_q;
	logic       out_a20_q;

	logic       accept;
	logic       out_load;
	logic       need_pop;
	logic       is_arm;

	kbc_pkg::kbc_fifo_ctl_t  fifo_ctl;
	kbc_pkg::kbc_fifo_stat_t fifo_stat;
	logic [7:0]              fifo_rd;

	// data-port read with the buffer full and bytes waiting refills from the queue
	assign need_pop = (func_q == kbc_pkg::FN_READ) && (port_q == kbc_pkg::PORT_DATA) &&
		status_q[kbc_pkg::ST_OBF] && !fifo_stat.empty;

	assign is_arm = (value_q == kbc_pkg::CMD_WRITE_CB) || (value_q == kbc_pkg::CMD_WRITE_OUT) ||
		(value_q == kbc_pkg::CMD_WRITE_KBO) || (value_q == kbc_pkg::CMD_WRITE_AUX);

	// bytes an item sends to the host
	always_comb begin
		emit_d[0] = kbc_pkg::BYTE_ZERO;
		emit_d[1] = kbc_pkg::BYTE_ZERO;
		emit_d[2] = kbc_pkg::BYTE_ZERO;
		emit_n_d  = 2'd0;
		case (func_q)
			kbc_pkg::FN_KBD: begin
				emit_d[0] = value_q;
				emit_n_d  = 2'd1;
			end
			kbc_pkg::FN_WRITE: begin
				if (port_q == kbc_pkg::PORT_DATA) begin
					if (pending_q == kbc_pkg::PEND_NONE) begin
						emit_d[0] = kbc_pkg::BYTE_ACK;
						emit_n_d  = 2'd1;
					end else if (pending_q == kbc_pkg::CMD_WRITE_AUX) begin
						emit_d[0] = kbc_pkg::BYTE_ACK;
						emit_n_d  = 2'd1;
						// aux reset answers ack, self-test pass, device id
						if (value_q == kbc_pkg::BYTE_RESET) begin
							emit_d[1] = kbc_pkg::BYTE_BAT_OK;
							emit_d[2] = kbc_pkg::BYTE_ZERO;
							emit_n_d  = 2'd3;
						end
					end
				end else if (port_q == kbc_pkg::PORT_CMD) begin
					case (value_q)
						kbc_pkg::CMD_READ_CB: begin
							emit_d[0] = control_q;
							emit_n_d  = 2'd1;
						end
						kbc_pkg::CMD_SELF_TEST: begin
							emit_d[0] = kbc_pkg::BYTE_TEST_OK;
							emit_n_d  = 2'd1;
						end
						kbc_pkg::CMD_READ_IN, kbc_pkg::CMD_READ_TST: begin
							emit_d[0] = kbc_pkg::BYTE_ZERO;
							emit_n_d  = 2'd1;
						end
						kbc_pkg::CMD_READ_OUT: begin
							emit_d[0] = out_port_q;
							emit_n_d  = 2'd1;
						end
						default: begin
							emit_n_d = 2'd0;
						end
					endcase
				end
			end
			default: begin
				emit_n_d = 2'd0;
			end
		endcase
	end

	// sequencer: next state and strobes
	always_comb begin
		state_nx     = state_q;
		in_ready     = 1'b0;
		fifo_ctl     = '0;
		out_load     = 1'b0;
		case (state_q)
			kbc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nx = kbc_pkg::ST_EXEC;
				end
			end
			kbc_pkg::ST_EXEC: begin
				if (need_pop) begin
					fifo_ctl.pop = 1'b1;
					state_nx     = kbc_pkg::ST_POP;
				end else if (emit_n_d != 2'd0) begin
					state_nx = kbc_pkg::ST_EMIT;
				end else begin
					state_nx = kbc_pkg::ST_DONE;
				end
			end
			kbc_pkg::ST_EMIT: begin
				// buffer already full: byte goes to the queue unless the queue is full
				fifo_ctl.push = status_q[kbc_pkg::ST_OBF] && !fifo_stat.full;
				if (emit_n_q == 2'd1) begin
					state_nx = kbc_pkg::ST_DONE;
				end
			end
			kbc_pkg::ST_POP: begin
				state_nx = kbc_pkg::ST_DONE;
			end
			kbc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_nx = kbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = kbc_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			port_q  <= port_select;
			value_q <= value;
		end
	end

	// controller registers, updated step by step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= kbc_pkg::STATUS_RST;
			control_q  <= kbc_pkg::CB_RST;
			out_port_q <= kbc_pkg::OUTPORT_RST;
			pending_q  <= kbc_pkg::PEND_NONE;
			obuf_q     <= kbc_pkg::BYTE_ZERO;
			gate_q     <= '0;
			a20_q      <= 1'b0;
			rd_q       <= '0;
			irq_q      <= 1'b0;
			rst_q      <= 1'b0;
			emit_n_q   <= 2'd0;
		end else begin
			case (state_q)
				kbc_pkg::ST_IDLE: begin
					if (accept) begin
						rd_q  <= '0;
						irq_q <= 1'b0;
						rst_q <= 1'b0;
					end
				end
				kbc_pkg::ST_EXEC: begin
					emit_n_q <= emit_n_d;
					case (func_q)
						kbc_pkg::FN_READ: begin
							case (port_q)
								kbc_pkg::PORT_DATA: begin
									rd_q <= obuf_q;
									// last byte taken: output buffer goes empty
									if (status_q[kbc_pkg::ST_OBF] && fifo_stat.empty) begin
										status_q[kbc_pkg::ST_OBF] <= 1'b0;
									end
								end
								kbc_pkg::PORT_CMD:  rd_q <= status_q;
								kbc_pkg::PORT_GATE: rd_q <= gate_q;
								default:            rd_q <= kbc_pkg::BYTE_NO_PORT;
							endcase
						end
						kbc_pkg::FN_WRITE: begin
							case (port_q)
								kbc_pkg::PORT_DATA: begin
									if (pending_q == kbc_pkg::CMD_WRITE_CB) begin
										control_q <= value_q;
									end else if (pending_q == kbc_pkg::CMD_WRITE_OUT) begin
										out_port_q <= value_q;
										a20_q      <= value_q[1];
									end
									if (pending_q != kbc_pkg::PEND_NONE) begin
										status_q[kbc_pkg::ST_IBF] <= 1'b0;
									end
									pending_q <= kbc_pkg::PEND_NONE;
								end
								kbc_pkg::PORT_CMD: begin
									// data commands arm and hold input-full until their byte
									if (is_arm) begin
										pending_q                 <= value_q;
										status_q[kbc_pkg::ST_IBF] <= 1'b1;
									end else begin
										pending_q                 <= kbc_pkg::PEND_NONE;
										status_q[kbc_pkg::ST_IBF] <= 1'b0;
									end
									case (value_q)
										kbc_pkg::CMD_KBD_OFF:
											control_q[kbc_pkg::CB_KBD_DIS] <= 1'b1;
										kbc_pkg::CMD_KBD_ON:
											control_q[kbc_pkg::CB_KBD_DIS] <= 1'b0;
										kbc_pkg::CMD_AUX_OFF:
											control_q[kbc_pkg::CB_AUX_DIS] <= 1'b1;
										kbc_pkg::CMD_AUX_ON:
											control_q[kbc_pkg::CB_AUX_DIS] <= 1'b0;
										kbc_pkg::CMD_PULSE_RST:
											rst_q <= 1'b1;
										default: begin
										end
									endcase
								end
								kbc_pkg::PORT_GATE: begin
									gate_q <= value_q;
									a20_q  <= value_q[1];
								end
								default: begin
								end
							endcase
						end
						default: begin
						end
					endcase
				end
				kbc_pkg::ST_EMIT: begin
					// empty buffer takes the byte directly and may interrupt
					if (!status_q[kbc_pkg::ST_OBF]) begin
						obuf_q                    <= emit_q[0];
						status_q[kbc_pkg::ST_OBF] <= 1'b1;
						if (control_q[kbc_pkg::CB_IRQ_EN]) begin
							irq_q <= 1'b1;
						end
					end
					emit_n_q <= emit_n_q - 2'd1;
				end
				kbc_pkg::ST_POP: begin
					obuf_q <= fifo_rd;
					if (control_q[kbc_pkg::CB_IRQ_EN]) begin
						irq_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// pending host bytes, shifted out one per emit cycle
	always_ff @(posedge clk) begin
		if (state_q == kbc_pkg::ST_EXEC) begin
			emit_q[0] <= emit_d[0];
			emit_q[1] <= emit_d[1];
			emit_q[2] <= emit_d[2];
		end else if (state_q == kbc_pkg::ST_EMIT) begin
			emit_q[0] <= emit_q[1];
			emit_q[1] <= emit_q[2];
		end
	end

	kbc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fifo_ctl),
		.push_data (emit_q[0]),
		.pop_data  (fifo_rd),
		.stat      (fifo_stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rd_q  <= rd_q;
			out_irq_q <= irq_q;
			out_rst_q <= rst_q;
			out_a20_q <= a20_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_data         = out_rd_q;
	assign irq_request       = out_irq_q;
	assign cpu_reset_request = out_rst_q;
	assign gate_a20          = out_a20_q;

	// bytes in the queue keep output-full set
	`KBC_ASSERT_NOW(a_obf_while_queued, !fifo_stat.empty, status_q[kbc_pkg::ST_OBF], "queue holds bytes with output-full clear")
	// a refill never reads an empty queue
	`KBC_ASSERT_NOW(a_pop_not_empty, fifo_ctl.pop, !fifo_stat.empty, "queue read while empty")
	// an accepted transfer starts execution next cycle
	`KBC_ASSERT_NEXT(a_accept_exec, accept, state_q == kbc_pkg::ST_EXEC, "accepted item not executed")

endmodule
